// ===== src/length_prefixed_frame_receiver_macros.svh =====
// Assertion macros used by the frame receiver checker.
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define LPFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define LPFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/lpfr_pkg.sv =====
// Types and constants shared by the frame receiver modules.
`timescale 1ns / 1ps
package lpfr_pkg;

  localparam logic [7:0] START_BYTE   = 8'h7E;
  localparam int         HEADER_BYTES = 3;
  localparam int         SLOT_COUNT   = 2;
  localparam int         PENDING_W    = 8;
  localparam int         LEN_SUM_W    = 17;

  // Per-byte result flags
  typedef struct packed {
    logic frame_slot;
    logic frame_last;
    logic overlong;
  } flags_t;

endpackage

// ===== src/length_prefixed_frame_receiver.sv =====
// A result is registered in the result queue and offered to the result channel from there.
// Throughput: one byte per cycle, held by the two-entry result queue; rx_ready
// drops only while both queue entries wait on the result channel.
// Bytes hunted past before a start byte are accepted but give no result.
// Reset (rst, synchronous): back to hunting, pending count zero, queue empty.
`timescale 1ns / 1ps
module length_prefixed_frame_receiver #(
  parameter int FRAME_BYTES = 128,
  parameter int POS_W       = $clog2(FRAME_BYTES)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rx_valid,
  output logic             rx_ready,
  input  logic [7:0]       rx_byte,
  output logic             frame_valid,
  input  logic             frame_ready,
  output logic [7:0]       data_byte,
  output logic [POS_W-1:0] position,
  output logic             frame_slot,
  output logic             frame_last,
  output logic             overlong
);
  import lpfr_pkg::*;

  localparam int ENTRY_W = 8 + POS_W + $bits(flags_t);

  logic               accept;
  logic               result_valid;
  logic [POS_W-1:0]   result_position;
  flags_t             result_flags;
  flags_t             out_flags;
  logic [ENTRY_W-1:0] queue_in;
  logic [ENTRY_W-1:0] queue_out;

  assign accept = rx_valid && rx_ready;

  // Parse each accepted byte
  lpfr_parse #(
    .FRAME_BYTES (FRAME_BYTES),
    .POS_W       (POS_W)
  ) u_parse (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .rx_byte         (rx_byte),
    .result_valid    (result_valid),
    .result_position (result_position),
    .result_flags    (result_flags)
  );

  // Queue results toward the output channel
  assign queue_in = {rx_byte, result_position, result_flags};

  lpfr_fifo #(
    .W (ENTRY_W)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (result_valid),
    .wr_data  (queue_in),
    .wr_ready (rx_ready),
    .rd_valid (frame_valid),
    .rd_data  (queue_out),
    .rd_ready (frame_ready)
  );

  assign {data_byte, position, out_flags} = queue_out;
  assign frame_slot = out_flags.frame_slot;
  assign frame_last = out_flags.frame_last;
  assign overlong   = out_flags.overlong;

endmodule

// ===== src/lpfr_parse.sv =====
// Frame parser: position tracking, length decode and pending-frame count.
`timescale 1ns / 1ps
module lpfr_parse #(
  parameter int FRAME_BYTES = 128,
  parameter int POS_W       = $clog2(FRAME_BYTES)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  output logic              result_valid,
  output logic [POS_W-1:0]  result_position,
  output lpfr_pkg::flags_t  result_flags
);
  import lpfr_pkg::*;

  localparam logic [POS_W-1:0] POS_START  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(2);
  localparam logic [POS_W-1:0] POS_FIRST  = POS_W'(3);
  localparam logic [PENDING_W-1:0] PENDING_MAX = {PENDING_W{1'b1}};

  logic [POS_W-1:0]     byte_position, byte_position_next;
  logic [7:0]           length_high, length_high_next;
  logic [POS_W-1:0]     end_position, end_position_next;
  logic [PENDING_W-1:0] pending_frames, pending_frames_next;
  logic [LEN_SUM_W-1:0] end_sum;
  logic                 hit;
  logic                 last_flag;
  logic                 over_flag;

  // Frame end position from the two length bytes
  assign end_sum = LEN_SUM_W'({length_high, rx_byte}) + LEN_SUM_W'(HEADER_BYTES);

  // Decide the result and next state for the byte on the input
  always_comb begin
    hit                 = 1'b0;
    last_flag           = 1'b0;
    over_flag           = 1'b0;
    byte_position_next  = byte_position;
    length_high_next    = length_high;
    end_position_next   = end_position;
    pending_frames_next = pending_frames;
    case (byte_position)
      POS_START: begin
        if (rx_byte == START_BYTE) begin
          hit                = 1'b1;
          byte_position_next = POS_LEN_HI;
        end
      end
      POS_LEN_HI: begin
        hit                = 1'b1;
        length_high_next   = rx_byte;
        byte_position_next = POS_LEN_LO;
      end
      POS_LEN_LO: begin
        hit = 1'b1;
        if (end_sum >= LEN_SUM_W'(FRAME_BYTES)) begin
          over_flag          = 1'b1;
          byte_position_next = POS_START;
        end else begin
          end_position_next  = end_sum[POS_W-1:0];
          byte_position_next = POS_FIRST;
        end
      end
      default: begin
        hit = 1'b1;
        if (byte_position >= end_position) begin
          last_flag          = 1'b1;
          byte_position_next = POS_START;
          if (pending_frames != PENDING_MAX) begin
            pending_frames_next = pending_frames + PENDING_W'(1);
          end
        end else begin
          byte_position_next = byte_position + POS_W'(1);
        end
      end
    endcase
  end

  // Advance state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= POS_START;
      length_high    <= '0;
      end_position   <= '0;
      pending_frames <= '0;
    end else if (accept) begin
      byte_position  <= byte_position_next;
      length_high    <= length_high_next;
      end_position   <= end_position_next;
      pending_frames <= pending_frames_next;
    end
  end

  // Result fields for the current byte
  assign result_valid            = accept && hit;
  assign result_position         = byte_position;
  assign result_flags.frame_slot =
    (pending_frames < PENDING_W'(SLOT_COUNT)) ? pending_frames[0] : 1'b0;
  assign result_flags.frame_last = last_flag;
  assign result_flags.overlong   = over_flag;

endmodule

// ===== src/lpfr_fifo.sv =====
// Two-entry result queue that decouples the parser from the result channel.
`timescale 1ns / 1ps
module lpfr_fifo #(
  parameter int W = 18
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_valid,
  input  logic [W-1:0] wr_data,
  output logic         wr_ready,
  output logic         rd_valid,
  output logic [W-1:0] rd_data,
  input  logic         rd_ready
);
  import lpfr_pkg::*;

  localparam int DEPTH = 2;

  logic [W-1:0] entry [DEPTH];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         push;
  logic         pop;

  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  // Store incoming requests
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_data;
    end
  end

  // Track fill level and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  assign wr_ready = (count != 2'(DEPTH));
  assign rd_valid = (count != 2'd0);
  assign rd_data  = entry[rd_ptr];

endmodule

// ===== src/lpfr_checker.sv =====
// Port-level checks on the frame receiver, bound to the top level.
`timescale 1ns / 1ps
`include "length_prefixed_frame_receiver_macros.svh"
module lpfr_checker #(
  parameter int POS_W = 7
) (
  input logic             clk,
  input logic             rst,
  input logic             frame_valid,
  input logic             frame_ready,
  input logic [7:0]       data_byte,
  input logic [POS_W-1:0] position,
  input logic             frame_slot,
  input logic             frame_last,
  input logic             overlong
);
  import lpfr_pkg::*;

  // A dropped frame never completes
  `LPFR_ASSERT_NOW(a_last_not_over, frame_valid && frame_last, !overlong, "last byte flagged overlong")

  // Overlong is only reported on the second length byte
  `LPFR_ASSERT_NOW(a_over_pos, frame_valid && overlong, position == POS_W'(2), "overlong off length byte")

  // Position zero is always a start byte that does not end a frame
  `LPFR_ASSERT_NOW(a_start_byte, frame_valid && (position == '0), (data_byte == START_BYTE) && !frame_last, "bad start byte result")

  // A stalled request holds its position and its last and slot flags
  `LPFR_ASSERT_NEXT(a_stall_hold, frame_valid && !frame_ready, frame_valid && $stable(position) && $stable(frame_last) && $stable(frame_slot), "stalled request changed")

endmodule

bind length_prefixed_frame_receiver lpfr_checker #(
  .POS_W (POS_W)
) u_lpfr_checker (
  .clk         (clk),
  .rst         (rst),
  .frame_valid (frame_valid),
  .frame_ready (frame_ready),
  .data_byte   (data_byte),
  .position    (position),
  .frame_slot  (frame_slot),
  .frame_last  (frame_last),
  .overlong    (overlong)
);

// ===== tb/tb_length_prefixed_frame_receiver.sv =====
// Self-checking testbench for the length-prefixed frame receiver.
`timescale 1ns / 1ps
module tb_length_prefixed_frame_receiver;
  import lpfr_pkg::*;

  localparam int FRAME_BYTES     = 128;
  localparam int RANDOM_BYTES    = 620;
  localparam int IDLE_LIMIT      = 2000;
  localparam int DRAIN_CYCLES    = 8;

  // One reported byte with its frame position and flags
  typedef struct packed {
    logic [7:0] data;
    logic [6:0] pos;
    flags_t     flags;
  } rx_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic       rx_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       frame_valid;
  logic       frame_ready = 1'b0;
  logic [7:0] data_byte;
  logic [6:0] position;
  logic       frame_slot;
  logic       frame_last;
  logic       overlong;

  // Byte stream waiting to be sent, and decoded results waiting to come out
  logic [7:0] rx_backlog[$];
  rx_result_t due_results[$];

  // Receiver state as tracked by the decoder below
  logic [6:0] frame_pos = '0;
  logic [7:0] length_msb = '0;
  logic [6:0] checksum_pos = '0;
  logic [7:0] frames_held = '0;

  // Driver and monitor bookkeeping
  bit         rx_took = 1'b0;
  bit         rx_calm = 1'b0;
  bit         out_calm = 1'b0;
  int         rx_gap = 0;
  int         out_hold = 0;
  int         idle_cycles = 0;
  int         total_bytes = 0;
  int         bytes_taken = 0;
  int         results_checked = 0;
  int         mismatches = 0;
  int         frames_closed = 0;
  int         overlong_seen = 0;
  int         slot1_seen = 0;
  int         frames_queued = 0;
  rx_result_t seen, want;

  length_prefixed_frame_receiver #(
    .FRAME_BYTES(FRAME_BYTES)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_ready   (rx_ready),
    .rx_byte    (rx_byte),
    .frame_valid(frame_valid),
    .frame_ready(frame_ready),
    .data_byte  (data_byte),
    .position   (position),
    .frame_slot (frame_slot),
    .frame_last (frame_last),
    .overlong   (overlong)
  );

  always #4 clk = ~clk;

  // Pick an idle stretch: mostly none or short, now and then long
  function automatic int pick_pause(bit calm);
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Decode one accepted byte and queue the result it should produce
  task automatic decode_rx_byte(input logic [7:0] b);
    rx_result_t r;
    int         frame_end;
    r.data             = b;
    r.pos              = frame_pos;
    r.flags.frame_slot = (frames_held < SLOT_COUNT) ? frames_held[0] : 1'b0;
    r.flags.frame_last = 1'b0;
    r.flags.overlong   = 1'b0;
    if (frame_pos == 0) begin
      // drop anything but the start byte while hunting
      if (b != START_BYTE) begin
        return;
      end
      frame_pos = 7'd1;
    end else if (frame_pos == 1) begin
      length_msb = b;
      frame_pos  = 7'd2;
    end else if (frame_pos == 2) begin
      frame_end = int'(length_msb) * 256 + int'(b) + HEADER_BYTES;
      if (frame_end >= FRAME_BYTES) begin
        r.flags.overlong = 1'b1;
        frame_pos        = 7'd0;
      end else begin
        checksum_pos = frame_end[6:0];
        frame_pos    = 7'd3;
      end
    end else if (frame_pos >= checksum_pos) begin
      // checksum byte closes the frame; pending count saturates
      r.flags.frame_last = 1'b1;
      if (frames_held != 8'hFF) begin
        frames_held = frames_held + 8'd1;
      end
      frame_pos = 7'd0;
    end else begin
      frame_pos = frame_pos + 7'd1;
    end
    due_results.push_back(r);
  endtask

  // Queue a start byte and a two-byte length
  task automatic queue_header(input logic [7:0] hi, input logic [7:0] lo);
    rx_backlog.push_back(START_BYTE);
    rx_backlog.push_back(hi);
    rx_backlog.push_back(lo);
  endtask

  // Queue a well-formed frame with random payload and checksum
  task automatic queue_frame(input int len);
    logic [15:0] len_field;
    len_field = len[15:0];
    queue_header(len_field[15:8], len_field[7:0]);
    repeat (len) begin
      if ($urandom_range(0, 15) == 0) begin
        rx_backlog.push_back(START_BYTE);
      end else begin
        rx_backlog.push_back(8'($urandom_range(0, 255)));
      end
    end
    rx_backlog.push_back(8'($urandom_range(0, 255)));
    frames_queued++;
  endtask

  // Drive the byte channel on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
    end else if (!rx_valid || rx_took) begin
      if (rx_gap > 0) begin
        rx_valid <= 1'b0;
        rx_gap   <= rx_gap - 1;
      end else if (rx_backlog.size() > 0) begin
        rx_valid <= 1'b1;
        rx_byte  <= rx_backlog.pop_front();
        rx_gap   <= pick_pause(rx_calm);
        if ($urandom_range(0, 49) == 0) begin
          rx_calm <= !rx_calm;
        end
      end else begin
        rx_valid <= 1'b0;
      end
    end
  end

  // Stall the result channel on the falling edge
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) begin
      out_calm <= !out_calm;
    end
    if (rst) begin
      frame_ready <= 1'b0;
    end else if (out_hold > 0) begin
      frame_ready <= 1'b0;
      out_hold    <= out_hold - 1;
    end else begin
      frame_ready <= 1'b1;
      if ($urandom_range(0, 99) < 40) begin
        out_hold <= pick_pause(out_calm);
      end
    end
  end

  // Sample both channels on the rising edge: check results, then decode requests
  always @(posedge clk) begin
    rx_took <= !rst && rx_valid && rx_ready;
    if (!rst) begin
      if (frame_valid && frame_ready) begin
        seen.data             = data_byte;
        seen.pos              = position;
        seen.flags.frame_slot = frame_slot;
        seen.flags.frame_last = frame_last;
        seen.flags.overlong   = overlong;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: byte %02h pos %0d slot %b last %b over %b",
                     seen.data, seen.pos, seen.flags.frame_slot,
                     seen.flags.frame_last, seen.flags.overlong);
          end
        end else begin
          want = due_results.pop_front();
          if (seen.data !== want.data || seen.pos !== want.pos ||
              seen.flags.frame_slot !== want.flags.frame_slot ||
              seen.flags.frame_last !== want.flags.frame_last ||
              seen.flags.overlong !== want.flags.overlong) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d mismatch: want byte %02h pos %0d slot %b last %b over %b",
                       results_checked, want.data, want.pos, want.flags.frame_slot,
                       want.flags.frame_last, want.flags.overlong);
              $display("  got byte %02h pos %0d slot %b last %b over %b",
                       seen.data, seen.pos, seen.flags.frame_slot,
                       seen.flags.frame_last, seen.flags.overlong);
            end
          end
        end
        results_checked++;
        if (seen.flags.frame_last === 1'b1) begin
          frames_closed++;
        end
        if (seen.flags.overlong === 1'b1) begin
          overlong_seen++;
        end
        if (seen.flags.frame_slot === 1'b1) begin
          slot1_seen++;
        end
      end
      if (rx_valid && rx_ready) begin
        decode_rx_byte(rx_byte);
        bytes_taken++;
      end
    end
  end

  // End the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (rx_valid && rx_ready) || (frame_valid && frame_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: %0d of %0d bytes taken, %0d results outstanding",
               bytes_taken, total_bytes, due_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Build the byte stream, release reset, wait for the results to drain
  initial begin
    int pick;
    int random_bytes;
    int len;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] junk;

    // hunting drops plain noise
    rx_backlog.push_back(8'h00);
    rx_backlog.push_back(8'hFF);
    rx_backlog.push_back(8'h7F);
    // zero length: checksum follows the length field directly
    queue_header(8'h00, 8'h00);
    rx_backlog.push_back(8'h00);
    // start byte inside a frame is plain data; frame lands in slot 1
    queue_header(8'h00, 8'h01);
    rx_backlog.push_back(START_BYTE);
    rx_backlog.push_back(8'hFF);
    // overlong: one past the buffer, high byte set, all ones
    queue_header(8'h00, 8'h7D);
    queue_header(8'h01, 8'h00);
    queue_header(8'hFF, 8'hFF);
    // two frames pending: slot falls back to 0
    queue_header(8'h00, 8'h00);
    rx_backlog.push_back(8'h55);

    // random mix of frames, overlong headers, noise and raw bursts
    random_bytes = 0;
    while (random_bytes < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        len = $urandom_range(1, 5);
        repeat (len) begin
          junk = 8'($urandom_range(0, 255));
          if (junk == START_BYTE) begin
            junk = junk ^ 8'h01;
          end
          rx_backlog.push_back(junk);
        end
        random_bytes += len;
      end else if (pick < 16) begin
        hi = 8'($urandom_range(0, 255));
        if (hi == 8'h00 || $urandom_range(0, 1) == 0) begin
          hi = 8'h00;
          lo = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(125, 130))
                                           : 8'($urandom_range(125, 255));
        end else begin
          lo = 8'($urandom_range(0, 255));
        end
        queue_header(hi, lo);
        random_bytes += 3;
      end else if (pick < 21) begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          rx_backlog.push_back(8'($urandom_range(0, 255)));
        end
        random_bytes += len;
      end else begin
        if (pick < 26) begin
          len = ($urandom_range(0, 2) == 0) ? FRAME_BYTES - 1 - HEADER_BYTES
                                            : $urandom_range(60, FRAME_BYTES - 1 - HEADER_BYTES);
        end else begin
          len = $urandom_range(0, 12);
        end
        queue_frame(len);
        random_bytes += len + 4;
      end
    end
    total_bytes = rx_backlog.size();

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    while (bytes_taken < total_bytes) begin
      @(posedge clk);
    end
    while (due_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes (%0d random frames), checked %0d results: %0d closed, %0d overlong",
             bytes_taken, frames_queued, results_checked, frames_closed, overlong_seen);
    $display("slot 1 seen %0d times, pending count ended at %0d, %0d mismatches",
             slot1_seen, frames_held, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
